// ----- hdl/spcp_pkg.sv -----
// Shared constants and the path code type for the segment pair closest-points core.
package spcp_pkg;

  localparam int CASE_W  = 3;
  localparam int LIMIT_W = 16;

  typedef enum logic [CASE_W-1:0] {
    CODE_BOTH_POINT   = 3'd0,
    CODE_FIRST_POINT  = 3'd1,
    CODE_SECOND_POINT = 3'd2,
    CODE_GENERAL      = 3'd3,
    CODE_PARALLEL     = 3'd4
  } case_code_t;

endpackage

// ----- hdl/segment_pair_closest_points_core.sv -----
// Top level of the segment pair closest-points core: pipeline, selection and output register.
//
// Takes one request per cycle, when not stalled, holding the endpoints of two 2D
// segments in signed fixed point (COORD_BITS wide, FRAC_BITS fraction bits) and
// returns the closest point on each segment, their distance and a path code. The
// whole datapath is one pipeline that advances as a unit whenever the output
// register is empty or being taken, so while it advances one request enters and
// one result leaves in every cycle with no gaps; it stalls while a result waits.
// The pipeline runs through the two ratio dividers (FRAC_BITS+2 stages each, one
// quotient bit per stage) and the square root (COORD_BITS+2 stages, one root bit
// per stage). The degenerate limit is written through cfg_we/cfg_wdata and is
// read by the point tests in the third stage, so write it only while no request
// is in flight.
module segment_pair_closest_points_core #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [spcp_pkg::LIMIT_W-1:0]    cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [COORD_BITS-1:0]    in_start1_x,
  input  logic signed [COORD_BITS-1:0]    in_start1_y,
  input  logic signed [COORD_BITS-1:0]    in_end1_x,
  input  logic signed [COORD_BITS-1:0]    in_end1_y,
  input  logic signed [COORD_BITS-1:0]    in_start2_x,
  input  logic signed [COORD_BITS-1:0]    in_start2_y,
  input  logic signed [COORD_BITS-1:0]    in_end2_x,
  input  logic signed [COORD_BITS-1:0]    in_end2_y,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [COORD_BITS-1:0]    out_near1_x,
  output logic signed [COORD_BITS-1:0]    out_near1_y,
  output logic signed [COORD_BITS-1:0]    out_near2_x,
  output logic signed [COORD_BITS-1:0]    out_near2_y,
  output logic [COORD_BITS:0]             out_separation,
  output logic [spcp_pkg::CASE_W-1:0]     out_case_code
);

  localparam int C    = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int DW   = C + 1;          // coordinate differences
  localparam int PRW  = 2 * DW;         // product of two differences
  localparam int PW   = 2 * C + 3;      // dot products
  localparam int DW1  = 2 * PW + 1;     // first ratio operands
  localparam int DW2  = PW + F + 2;     // second ratio operands
  localparam int SW   = F + 1;          // segment parameter
  localparam int SPW  = DW + SW + 1;    // difference times parameter
  localparam int SQ_W = 2 * C + 2;      // squared distance
  localparam int CW   = spcp_pkg::CASE_W;

  localparam logic [SW-1:0]  ONE_S  = {1'b1, {F{1'b0}}};
  localparam logic [SPW-1:0] HALF_P = SPW'(1) << (F - 1);

  typedef struct packed {
    logic signed [C-1:0]  p1x, p1y, p2x, p2y;
    logic signed [DW-1:0] d1x, d1y, d2x, d2y;
  } geo_t;

  typedef struct packed {
    logic signed [PW-1:0] a, b, c, e, f;
  } coef_t;

  localparam int SB1W = $bits(geo_t) + $bits(coef_t) + CW;
  localparam int SB2W = $bits(geo_t) + CW + 1 + SW;
  localparam int SB3W = 4 * C + CW;

  function automatic logic signed [DW-1:0] rnd_q(input logic signed [SPW-1:0] p);
    logic [SPW-1:0] mag;
    logic [SPW-1:0] sh;
    mag = p[SPW-1] ? (~p + 1'b1) : p;
    sh  = (mag + HALF_P) >> F;
    return p[SPW-1] ? (~DW'(sh) + 1'b1) : DW'(sh);
  endfunction

  logic adv;
  logic out_valid_r;
  logic [spcp_pkg::LIMIT_W-1:0] limit_r;

  // The whole pipeline moves together; hold everything while a result waits.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // ---------------- stage 1: differences ----------------
  logic v1_r;
  geo_t geo1_r;
  logic signed [DW-1:0] rx_r, ry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      geo1_r.p1x <= in_start1_x;
      geo1_r.p1y <= in_start1_y;
      geo1_r.p2x <= in_start2_x;
      geo1_r.p2y <= in_start2_y;
      geo1_r.d1x <= DW'(in_end1_x) - DW'(in_start1_x);
      geo1_r.d1y <= DW'(in_end1_y) - DW'(in_start1_y);
      geo1_r.d2x <= DW'(in_end2_x) - DW'(in_start2_x);
      geo1_r.d2y <= DW'(in_end2_y) - DW'(in_start2_y);
      rx_r       <= DW'(in_start1_x) - DW'(in_start2_x);
      ry_r       <= DW'(in_start1_y) - DW'(in_start2_y);
    end
  end

  // ---------------- stage 2: dot products ----------------
  logic signed [PRW-1:0] m_a0, m_a1, m_b0, m_b1, m_c0, m_c1, m_e0, m_e1, m_f0, m_f1;
  logic v2_r;
  geo_t geo2_r;
  coef_t cf2_r;

  assign m_a0 = geo1_r.d1x * geo1_r.d1x;
  assign m_a1 = geo1_r.d1y * geo1_r.d1y;
  assign m_b0 = geo1_r.d1x * geo1_r.d2x;
  assign m_b1 = geo1_r.d1y * geo1_r.d2y;
  assign m_c0 = geo1_r.d1x * rx_r;
  assign m_c1 = geo1_r.d1y * ry_r;
  assign m_e0 = geo1_r.d2x * geo1_r.d2x;
  assign m_e1 = geo1_r.d2y * geo1_r.d2y;
  assign m_f0 = geo1_r.d2x * rx_r;
  assign m_f1 = geo1_r.d2y * ry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      geo2_r  <= geo1_r;
      cf2_r.a <= PW'(m_a0) + PW'(m_a1);
      cf2_r.b <= PW'(m_b0) + PW'(m_b1);
      cf2_r.c <= PW'(m_c0) + PW'(m_c1);
      cf2_r.e <= PW'(m_e0) + PW'(m_e1);
      cf2_r.f <= PW'(m_f0) + PW'(m_f1);
    end
  end

  // ---------------- stages 3-4: wide cross products, point tests ----------------
  logic signed [2*PW-1:0] ae, bb, bf, ce;

  spcp_wmul #(.W(PW)) u_mul_ae (.clk(clk), .en(adv), .x(cf2_r.a), .y(cf2_r.e), .p(ae));
  spcp_wmul #(.W(PW)) u_mul_bb (.clk(clk), .en(adv), .x(cf2_r.b), .y(cf2_r.b), .p(bb));
  spcp_wmul #(.W(PW)) u_mul_bf (.clk(clk), .en(adv), .x(cf2_r.b), .y(cf2_r.f), .p(bf));
  spcp_wmul #(.W(PW)) u_mul_ce (.clk(clk), .en(adv), .x(cf2_r.c), .y(cf2_r.e), .p(ce));

  logic v3_r, v4_r;
  geo_t geo3_r, geo4_r;
  coef_t cf3_r, cf4_r;
  logic pt1_3_r, pt2_3_r, pt1_4_r, pt2_4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      geo3_r  <= geo2_r;
      cf3_r   <= cf2_r;
      pt1_3_r <= $unsigned(cf2_r.a) <= PW'(limit_r);
      pt2_3_r <= $unsigned(cf2_r.e) <= PW'(limit_r);
      geo4_r  <= geo3_r;
      cf4_r   <= cf3_r;
      pt1_4_r <= pt1_3_r;
      pt2_4_r <= pt2_3_r;
    end
  end

  // ---------------- first ratio: s on the infinite lines ----------------
  logic signed [DW1-1:0] num1, den1;
  logic [CW-1:0] code4;

  assign den1 = DW1'(ae) - DW1'(bb);
  assign num1 = DW1'(bf) - DW1'(ce);

  always_comb begin
    if (pt1_4_r && pt2_4_r) begin
      code4 = spcp_pkg::CODE_BOTH_POINT;
    end else if (pt1_4_r) begin
      code4 = spcp_pkg::CODE_FIRST_POINT;
    end else if (pt2_4_r) begin
      code4 = spcp_pkg::CODE_SECOND_POINT;
    end else if (den1 == '0) begin
      code4 = spcp_pkg::CODE_PARALLEL;
    end else begin
      code4 = spcp_pkg::CODE_GENERAL;
    end
  end

  logic d1_v;
  logic [SW-1:0] d1_q;
  logic [SB1W-1:0] sb1_o;
  geo_t geo_d1;
  coef_t cf_d1;
  logic [CW-1:0] code_d1;

  // A zero denominator yields zero here, which is the parallel case's s.
  spcp_div #(.W(DW1), .STEPS(SW), .SBW(SB1W)) u_div_s (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v4_r),
    .num(num1), .den(den1), .in_sb({geo4_r, cf4_r, code4}),
    .out_valid(d1_v), .quo(d1_q), .out_sb(sb1_o)
  );

  assign {geo_d1, cf_d1, code_d1} = sb1_o;

  // ---------------- t numerator ----------------
  logic signed [DW2-1:0] bs;
  logic v5_r;
  geo_t geo5_r;
  coef_t cf5_r;
  logic [CW-1:0] code5_r;
  logic [SW-1:0] s0_r;
  logic signed [DW2-1:0] tn_r, td_r;

  assign bs = cf_d1.b * $signed({1'b0, d1_q});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      geo5_r  <= geo_d1;
      cf5_r   <= cf_d1;
      code5_r <= code_d1;
      s0_r    <= d1_q;
      tn_r    <= bs + (DW2'(cf_d1.f) <<< F);
      td_r    <= DW2'(cf_d1.e) <<< F;
    end
  end

  // ---------------- second ratio: pick operands per path ----------------
  logic signed [DW2-1:0] num2, den2;
  logic dest_s;
  logic [SW-1:0] other;

  always_comb begin
    num2   = '0;
    den2   = '0;
    dest_s = 1'b1;
    other  = '0;
    unique case (code5_r) inside
      spcp_pkg::CODE_BOTH_POINT: begin
        dest_s = 1'b1;
      end
      spcp_pkg::CODE_FIRST_POINT: begin
        num2   = DW2'(cf5_r.f);
        den2   = DW2'(cf5_r.e);
        dest_s = 1'b0;
      end
      spcp_pkg::CODE_SECOND_POINT: begin
        num2 = -DW2'(cf5_r.c);
        den2 = DW2'(cf5_r.a);
      end
      spcp_pkg::CODE_GENERAL, spcp_pkg::CODE_PARALLEL: begin
        if (tn_r[DW2-1]) begin
          // t clamps at the start of segment two: redo s
          num2 = -DW2'(cf5_r.c);
          den2 = DW2'(cf5_r.a);
        end else if (td_r < tn_r) begin
          // t clamps at the end of segment two
          num2  = DW2'(cf5_r.b) - DW2'(cf5_r.c);
          den2  = DW2'(cf5_r.a);
          other = ONE_S;
        end else begin
          num2   = tn_r;
          den2   = td_r;
          dest_s = 1'b0;
          other  = s0_r;
        end
      end
      default: begin
        dest_s = 1'b1;
      end
    endcase
  end

  logic d2_v;
  logic [SW-1:0] d2_q;
  logic [SB2W-1:0] sb2_o;
  geo_t geo_d2;
  logic [CW-1:0] code_d2;
  logic dest_d2;
  logic [SW-1:0] other_d2;
  logic [SW-1:0] s_fin, t_fin;

  spcp_div #(.W(DW2), .STEPS(SW), .SBW(SB2W)) u_div_t (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v5_r),
    .num(num2), .den(den2), .in_sb({geo5_r, code5_r, dest_s, other}),
    .out_valid(d2_v), .quo(d2_q), .out_sb(sb2_o)
  );

  assign {geo_d2, code_d2, dest_d2, other_d2} = sb2_o;
  assign s_fin = dest_d2 ? d2_q : other_d2;
  assign t_fin = dest_d2 ? other_d2 : d2_q;

  // ---------------- closest points ----------------
  logic v6_r, v7_r, v8_r, v9_r;
  logic signed [SPW-1:0] pr1x_r, pr1y_r, pr2x_r, pr2y_r;
  logic signed [C-1:0] b1x_r, b1y_r, b2x_r, b2y_r;
  logic [CW-1:0] code6_r, code7_r, code8_r, code9_r;
  logic signed [C-1:0] n1x_r, n1y_r, n2x_r, n2y_r;
  logic signed [C-1:0] n1x8_r, n1y8_r, n2x8_r, n2y8_r;
  logic signed [C-1:0] n1x9_r, n1y9_r, n2x9_r, n2y9_r;
  logic signed [DW-1:0] dx_r, dy_r;
  logic signed [SQ_W-1:0] sqx_r, sqy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      v9_r <= 1'b0;
    end else if (adv) begin
      v6_r <= d2_v;
      v7_r <= v6_r;
      v8_r <= v7_r;
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pr1x_r  <= geo_d2.d1x * $signed({1'b0, s_fin});
      pr1y_r  <= geo_d2.d1y * $signed({1'b0, s_fin});
      pr2x_r  <= geo_d2.d2x * $signed({1'b0, t_fin});
      pr2y_r  <= geo_d2.d2y * $signed({1'b0, t_fin});
      b1x_r   <= geo_d2.p1x;
      b1y_r   <= geo_d2.p1y;
      b2x_r   <= geo_d2.p2x;
      b2y_r   <= geo_d2.p2y;
      code6_r <= code_d2;
      // round half away from zero and offset from the start point
      n1x_r   <= C'(DW'(b1x_r) + rnd_q(pr1x_r));
      n1y_r   <= C'(DW'(b1y_r) + rnd_q(pr1y_r));
      n2x_r   <= C'(DW'(b2x_r) + rnd_q(pr2x_r));
      n2y_r   <= C'(DW'(b2y_r) + rnd_q(pr2y_r));
      code7_r <= code6_r;
      dx_r    <= DW'(n1x_r) - DW'(n2x_r);
      dy_r    <= DW'(n1y_r) - DW'(n2y_r);
      n1x8_r  <= n1x_r;
      n1y8_r  <= n1y_r;
      n2x8_r  <= n2x_r;
      n2y8_r  <= n2y_r;
      code8_r <= code7_r;
      sqx_r   <= dx_r * dx_r;
      sqy_r   <= dy_r * dy_r;
      n1x9_r  <= n1x8_r;
      n1y9_r  <= n1y8_r;
      n2x9_r  <= n2x8_r;
      n2y9_r  <= n2y8_r;
      code9_r <= code8_r;
    end
  end

  // ---------------- distance ----------------
  logic [SQ_W-1:0] sq_sum;
  logic sq_v;
  logic [C:0] root;
  logic [SB3W-1:0] sb3_o;

  assign sq_sum = $unsigned(sqx_r) + $unsigned(sqy_r);

  spcp_sqrt #(.W(SQ_W), .SBW(SB3W)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v9_r), .val(sq_sum),
    .in_sb({n1x9_r, n1y9_r, n2x9_r, n2y9_r, code9_r}),
    .out_valid(sq_v), .root(root), .out_sb(sb3_o)
  );

  // ---------------- output register ----------------
  logic signed [C-1:0] on1x_r, on1y_r, on2x_r, on2y_r;
  logic [C:0] sep_r;
  logic [CW-1:0] ocode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      {on1x_r, on1y_r, on2x_r, on2y_r, ocode_r} <= sb3_o;
      sep_r <= root;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_near1_x    = on1x_r;
  assign out_near1_y    = on1y_r;
  assign out_near2_x    = on2x_r;
  assign out_near2_y    = on2y_r;
  assign out_separation = sep_r;
  assign out_case_code  = ocode_r;

  // ---------------- assertions ----------------
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_case_code <= spcp_pkg::CODE_PARALLEL))
    else $error("path code out of range");

  a_s_bound: assert property (@(posedge clk) disable iff (!rst_n)
    d1_v |-> (d1_q <= ONE_S))
    else $error("first ratio above one");

  a_t_bound: assert property (@(posedge clk) disable iff (!rst_n)
    d2_v |-> (d2_q <= ONE_S))
    else $error("second ratio above one");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v9_r && !adv) |=> v9_r)
    else $error("request dropped during stall");

endmodule

// ----- hdl/spcp_wmul.sv -----
// Two-stage signed multiplier built from four half-width partial products.
module spcp_wmul #(
  parameter int W = 51
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [W-1:0]   x,
  input  logic signed [W-1:0]   y,
  output logic signed [2*W-1:0] p
);

  localparam int H  = (W + 1) / 2;
  localparam int HW = W - H;
  localparam int PW = 2 * W;

  logic [W-1:0]      xm, ym;
  logic [2*H-1:0]    pp_ll_r;
  logic [H+HW-1:0]   pp_lh_r, pp_hl_r;
  logic [2*HW-1:0]   pp_hh_r;
  logic              neg_r;
  logic [PW-1:0]     mag;
  logic signed [PW-1:0] p_r;

  assign xm = x[W-1] ? (~x + 1'b1) : x;
  assign ym = y[W-1] ? (~y + 1'b1) : y;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll_r <= xm[H-1:0] * ym[H-1:0];
      pp_lh_r <= xm[H-1:0] * ym[W-1:H];
      pp_hl_r <= xm[W-1:H] * ym[H-1:0];
      pp_hh_r <= xm[W-1:H] * ym[W-1:H];
      neg_r   <= x[W-1] ^ y[W-1];
    end
  end

  assign mag = PW'(pp_ll_r) + (PW'(pp_lh_r) << H) + (PW'(pp_hl_r) << H)
             + (PW'(pp_hh_r) << (2 * H));

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= neg_r ? (~mag + 1'b1) : mag;
    end
  end

  assign p = p_r;

endmodule

// ----- hdl/spcp_div.sv -----
// Pipelined clamped ratio unit: num/den in [0,1], one quotient bit per stage.
module spcp_div #(
  parameter int W     = 103,
  parameter int STEPS = 13,
  parameter int SBW   = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [W-1:0] num,
  input  logic signed [W-1:0] den,
  input  logic [SBW-1:0]      in_sb,
  output logic                out_valid,
  output logic [STEPS-1:0]    quo,
  output logic [SBW-1:0]      out_sb
);

  localparam logic [STEPS-1:0] ONE_Q = {1'b1, {(STEPS-1){1'b0}}};

  logic             v_r    [0:STEPS];
  logic [W-1:0]     rem_r  [0:STEPS];
  logic [W-1:0]     den_r  [0:STEPS];
  logic [STEPS-1:0] q_r    [0:STEPS];
  logic             zero_r [0:STEPS];
  logic             one_r  [0:STEPS];
  logic [SBW-1:0]   sb_r   [0:STEPS];
  logic             zero_nxt, one_nxt;
  logic [STEPS:0]   rnd;

  assign zero_nxt = den[W-1] || (den == '0) || num[W-1] || (num == '0);
  assign one_nxt  = !(num < den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= num;
      den_r[0]  <= den;
      q_r[0]    <= '0;
      zero_r[0] <= zero_nxt;
      one_r[0]  <= one_nxt;
      sb_r[0]   <= in_sb;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [W:0] rem2, diff;
    logic       ge;

    always_comb begin
      rem2 = {rem_r[i], 1'b0};
      diff = rem2 - {1'b0, den_r[i]};
      ge   = !diff[W];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1]  <= ge ? diff[W-1:0] : rem2[W-1:0];
        den_r[i+1]  <= den_r[i];
        q_r[i+1]    <= {q_r[i][STEPS-2:0], ge};
        zero_r[i+1] <= zero_r[i];
        one_r[i+1]  <= one_r[i];
        sb_r[i+1]   <= sb_r[i];
      end
    end
  end

  // round half up on the extra quotient bit
  assign rnd       = ({1'b0, q_r[STEPS]} + 1'b1) >> 1;
  assign quo       = zero_r[STEPS] ? '0 : (one_r[STEPS] ? ONE_Q : rnd[STEPS-1:0]);
  assign out_valid = v_r[STEPS];
  assign out_sb    = sb_r[STEPS];

endmodule

// ----- hdl/spcp_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module spcp_sqrt #(
  parameter int W   = 50,
  parameter int SBW = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [W-1:0]     val,
  input  logic [SBW-1:0]   in_sb,
  output logic             out_valid,
  output logic [W/2-1:0]   root,
  output logic [SBW-1:0]   out_sb
);

  localparam int N = W / 2;

  logic           v_r   [0:N];
  logic [W-1:0]   rem_r [0:N];
  logic [W-1:0]   res_r [0:N];
  logic [SBW-1:0] sb_r  [0:N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= val;
      res_r[0] <= '0;
      sb_r[0]  <= in_sb;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic [W-1:0] STEP_BIT = W'(1) << (W - 2 - 2 * i);
    logic [W-1:0] trial;
    logic         take;

    assign trial = res_r[i] + STEP_BIT;
    assign take  = rem_r[i] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= take ? (rem_r[i] - trial) : rem_r[i];
        res_r[i+1] <= take ? ((res_r[i] >> 1) + STEP_BIT) : (res_r[i] >> 1);
        sb_r[i+1]  <= sb_r[i];
      end
    end
  end

  assign out_valid = v_r[N];
  assign root      = res_r[N][N-1:0];
  assign out_sb    = sb_r[N];

endmodule

// ----- tb/sv/tb_segment_pair_closest_points_core.sv -----
// Self-checking testbench for the segment pair closest-points core.
`timescale 1ns / 1ps

module tb_segment_pair_closest_points_core;

  localparam int CB       = 24;
  localparam int FB       = 12;
  localparam longint ONE  = 64'sd1 << FB;
  localparam longint HALF = 64'sd1 << (FB - 1);
  localparam longint CMAX = (64'sd1 << (CB - 1)) - 1;
  localparam longint CMIN = -(64'sd1 << (CB - 1));
  localparam longint SEP_SAT = (64'sd1 << (CB + 1)) - 1;
  localparam int DRAIN    = 2 * FB + CB + 40;  // latency plus margin
  localparam int STALL_LIMIT = 3000;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [CB-1:0] s1x, s1y, e1x, e1y, s2x, s2y, e2x, e2y;
  } seg_pair_t;

  typedef struct {
    logic [CB-1:0]        n1x, n1y, n2x, n2y;
    logic [CB:0]          sep;
    spcp_pkg::case_code_t code;
  } near_pair_t;

  // Scoreboard: predicts the nearest points of every accepted request and
  // holds them until the matching result comes back.
  class closest_pair_board;
    longint unsigned limit;
    near_pair_t      awaited[$];

    function new();
      limit = 0;
    endfunction

    // Parameter n/d clamped to [0,1] with FB fraction bits, halves up.
    function automatic longint clamp_ratio(wide_t n, wide_t d);
      logic [127:0] q;
      if (d <= 0 || n <= 0) return 0;
      if (n >= d) return ONE;
      q = $unsigned(n <<< (FB + 1)) / $unsigned(d);
      q = (q + 1) >> 1;
      if (q > ONE) return ONE;
      return longint'(q);
    endfunction

    // Point along a segment, rounded half away from zero.
    function automatic longint along(longint base, longint d, longint s);
      longint p;
      p = d * s;
      if (p >= 0) return base + ((p + HALF) >>> FB);
      return base - ((-p + HALF) >>> FB);
    endfunction

    function automatic longint root_floor(longint unsigned v);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= r + bitv) begin
          v -= r + bitv;
          r = (r >> 1) + bitv;
        end else begin
          r >>= 1;
        end
        bitv >>= 2;
      end
      return longint'(r);
    endfunction

    function automatic near_pair_t nearest(seg_pair_t q);
      longint p1x, p1y, p2x, p2y, d1x, d1y, d2x, d2y, rx, ry;
      longint a, b, c, e, f, s, t, n1x, n1y, n2x, n2y, dx, dy, span_len;
      wide_t denom, tn, td;
      near_pair_t r;
      p1x = longint'(q.s1x); p1y = longint'(q.s1y);
      p2x = longint'(q.s2x); p2y = longint'(q.s2y);
      d1x = longint'(q.e1x) - p1x; d1y = longint'(q.e1y) - p1y;
      d2x = longint'(q.e2x) - p2x; d2y = longint'(q.e2y) - p2y;
      rx = p1x - p2x; ry = p1y - p2y;
      a = d1x * d1x + d1y * d1y;
      e = d2x * d2x + d2y * d2y;
      f = d2x * rx + d2y * ry;
      c = d1x * rx + d1y * ry;
      b = d1x * d2x + d1y * d2y;
      s = 0;
      t = 0;
      if (a <= limit && e <= limit) begin
        r.code = spcp_pkg::CODE_BOTH_POINT;
      end else if (a <= limit) begin
        r.code = spcp_pkg::CODE_FIRST_POINT;
        t = clamp_ratio(wide_t'(f), wide_t'(e));
      end else if (e <= limit) begin
        r.code = spcp_pkg::CODE_SECOND_POINT;
        s = clamp_ratio(wide_t'(-c), wide_t'(a));
      end else begin
        denom = wide_t'(a) * wide_t'(e) - wide_t'(b) * wide_t'(b);
        if (denom == 0) begin
          r.code = spcp_pkg::CODE_PARALLEL;
        end else begin
          r.code = spcp_pkg::CODE_GENERAL;
          s = clamp_ratio(wide_t'(b) * wide_t'(f) - wide_t'(c) * wide_t'(e), denom);
        end
        tn = wide_t'(b) * wide_t'(s) + wide_t'(f) * wide_t'(ONE);
        td = wide_t'(e) * wide_t'(ONE);
        if (tn < 0) begin
          s = clamp_ratio(wide_t'(-c), wide_t'(a));
        end else if (tn > td) begin
          t = ONE;
          s = clamp_ratio(wide_t'(b - c), wide_t'(a));
        end else begin
          t = clamp_ratio(tn, td);
        end
      end
      n1x = along(p1x, d1x, s); n1y = along(p1y, d1y, s);
      n2x = along(p2x, d2x, t); n2y = along(p2y, d2y, t);
      dx = n1x - n2x; dy = n1y - n2y;
      span_len = root_floor(longint'(dx * dx + dy * dy));
      if (span_len > SEP_SAT) span_len = SEP_SAT;
      r.n1x = n1x[CB-1:0]; r.n1y = n1y[CB-1:0];
      r.n2x = n2x[CB-1:0]; r.n2y = n2y[CB-1:0];
      r.sep = span_len[CB:0];
      return r;
    endfunction

    function void note_request(seg_pair_t q);
      awaited.push_back(nearest(q));
    endfunction

    // Compare against the oldest prediction; return the mismatching fields.
    function string check_result(near_pair_t got);
      near_pair_t w;
      string why;
      if (awaited.size() == 0) return "result with no request outstanding";
      w = awaited.pop_front();
      why = "";
      if (got.n1x !== w.n1x) why = {why, $sformatf(" near1_x %0h/%0h", got.n1x, w.n1x)};
      if (got.n1y !== w.n1y) why = {why, $sformatf(" near1_y %0h/%0h", got.n1y, w.n1y)};
      if (got.n2x !== w.n2x) why = {why, $sformatf(" near2_x %0h/%0h", got.n2x, w.n2x)};
      if (got.n2y !== w.n2y) why = {why, $sformatf(" near2_y %0h/%0h", got.n2y, w.n2y)};
      if (got.sep !== w.sep) why = {why, $sformatf(" separation %0d/%0d", got.sep, w.sep)};
      if (got.code !== w.code) why = {why, $sformatf(" case_code %0d/%0d", got.code, w.code)};
      return why;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [spcp_pkg::LIMIT_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CB-1:0] in_start1_x = '0, in_start1_y = '0, in_end1_x = '0, in_end1_y = '0;
  logic signed [CB-1:0] in_start2_x = '0, in_start2_y = '0, in_end2_x = '0, in_end2_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CB-1:0] out_near1_x, out_near1_y, out_near2_x, out_near2_y;
  logic [CB:0] out_separation;
  logic [spcp_pkg::CASE_W-1:0] out_case_code;

  closest_pair_board pairs = new();
  int  mismatches = 0;
  bit  steady = 0;   // when set, neither side idles
  int  quiet_cycles = 0;

  always #6 clk = ~clk;

  segment_pair_closest_points_core #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_start1_x(in_start1_x), .in_start1_y(in_start1_y),
    .in_end1_x(in_end1_x), .in_end1_y(in_end1_y),
    .in_start2_x(in_start2_x), .in_start2_y(in_start2_y),
    .in_end2_x(in_end2_x), .in_end2_y(in_end2_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_near1_x(out_near1_x), .out_near1_y(out_near1_y),
    .out_near2_x(out_near2_x), .out_near2_y(out_near2_y),
    .out_separation(out_separation), .out_case_code(out_case_code)
  );

  task automatic report(string why);
    mismatches++;
    $display("mismatch at %0t:%s", $realtime, why);
  endtask

  // Hold off for the draw, then offer a request and hold it until taken.
  task automatic send_pair(seg_pair_t q);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_start1_x = q.s1x; in_start1_y = q.s1y; in_end1_x = q.e1x; in_end1_y = q.e1y;
    in_start2_x = q.s2x; in_start2_y = q.s2y; in_end2_x = q.e2x; in_end2_y = q.e2y;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pairs.note_request(q);
    @(negedge clk);
  endtask

  function automatic seg_pair_t pair_of(longint v0, v1, v2, v3, v4, v5, v6, v7);
    seg_pair_t q;
    q.s1x = CB'(v0); q.s1y = CB'(v1); q.e1x = CB'(v2); q.e1y = CB'(v3);
    q.s2x = CB'(v4); q.s2y = CB'(v5); q.e2x = CB'(v6); q.e2y = CB'(v7);
    return q;
  endfunction

  // Signed value spanning w bits.
  function automatic longint coord_w(int w);
    return longint'($urandom_range(0, (1 << w) - 1)) - (longint'(1) << (w - 1));
  endfunction

  function automatic longint nudge(longint base, int span);
    longint v;
    v = base + $urandom_range(0, 2 * span) - span;
    if (v > CMAX) v = CMAX;
    if (v < CMIN) v = CMIN;
    return v;
  endfunction

  // Random pair: a mix of wide noise, short segments and parallel pairs.
  function automatic seg_pair_t random_pair();
    seg_pair_t q;
    int w, k, span;
    longint x, y, dx, dy;
    w = $urandom_range(2, CB);
    k = $urandom_range(0, 9);
    span = $urandom_range(0, 3) == 0 ? 200 : 2;
    q = pair_of(coord_w(w), coord_w(w), coord_w(w), coord_w(w),
                coord_w(w), coord_w(w), coord_w(w), coord_w(w));
    case (k)
      0, 1: q = pair_of(coord_w(CB), coord_w(CB), coord_w(CB), coord_w(CB),
                        coord_w(CB), coord_w(CB), coord_w(CB), coord_w(CB));
      2: begin
        q.e1x = CB'(nudge(q.s1x, span)); q.e1y = CB'(nudge(q.s1y, span));
      end
      3: begin
        q.e2x = CB'(nudge(q.s2x, span)); q.e2y = CB'(nudge(q.s2y, span));
      end
      4: begin
        q.e1x = CB'(nudge(q.s1x, span)); q.e1y = CB'(nudge(q.s1y, span));
        q.e2x = CB'(nudge(q.s2x, span)); q.e2y = CB'(nudge(q.s2y, span));
      end
      5: begin
        // parallel or antiparallel: second direction a multiple of the first
        x = coord_w(w > 20 ? 20 : w) >>> 2; y = coord_w(w > 20 ? 20 : w) >>> 2;
        dx = coord_w(w > 20 ? 20 : w) >>> 3; dy = coord_w(w > 20 ? 20 : w) >>> 3;
        k = $urandom_range(1, 3);
        if ($urandom_range(0, 1)) k = -k;
        q = pair_of(x, y, x + dx, y + dy, q.s2x >>> 2, q.s2y >>> 2,
                    (q.s2x >>> 2) + k * dx, (q.s2y >>> 2) + k * dy);
      end
      default: ;
    endcase
    return q;
  endfunction

  task automatic write_limit(int unsigned v);
    cfg_wdata = v[spcp_pkg::LIMIT_W-1:0];
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    pairs.limit = longint'(v);
  endtask

  // Pause the sender until every outstanding request has returned.
  task automatic drain();
    in_valid = 1'b0;
    while (pairs.awaited.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  // Receiver: draw a stall per result, then take it and check it.
  initial begin
    int stall;
    near_pair_t got;
    string why;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      got.n1x = out_near1_x; got.n1y = out_near1_y;
      got.n2x = out_near2_x; got.n2y = out_near2_y;
      got.sep = out_separation; got.code = spcp_pkg::case_code_t'(out_case_code);
      why = pairs.check_result(got);
      if (why != "") report(why);
      @(negedge clk);
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned limits[6];
    limits = '{0, 65535, 1, 0, 200, 0};
    limits[3] = $urandom_range(2, 65534);
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed requests at limit 0: degenerate pairs, clamps, parallels, extremes.
    write_limit(0);
    send_pair(pair_of(100, 200, 100, 200, -300, 50, -300, 50));
    send_pair(pair_of(0, 4096, 0, 4096, -4096, 0, 4096, 0));
    send_pair(pair_of(-4096, 0, 4096, 0, 1000, -5000, 1000, -5000));
    send_pair(pair_of(-4096, -4096, 4096, 4096, -4096, 4096, 4096, -4096));
    send_pair(pair_of(0, 0, 8192, 0, 0, 4096, 8192, 4096));
    send_pair(pair_of(0, 0, 8192, 0, 12288, 4096, 4096, 4096));
    send_pair(pair_of(0, 0, 8192, 0, 4096, 0, 12288, 0));
    send_pair(pair_of(0, 0, 4096, 0, 8192, 1000, 8192, 9000));
    send_pair(pair_of(0, 0, 4096, 0, 2000, -9000, 2000, -1000));
    send_pair(pair_of(0, 0, 4096, 0, -8192, 3000, -8192, 9000));
    send_pair(pair_of(0, 0, 4096, 4096, 4096, 0, 12288, -3));
    send_pair(pair_of(CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMIN));
    send_pair(pair_of(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN));
    send_pair(pair_of(CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX));
    send_pair(pair_of(CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMAX, CMIN));
    send_pair(pair_of(CMAX, CMIN, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX));
    send_pair(pair_of(CMIN, 0, CMAX, 0, 0, CMIN, 0, CMAX));
    send_pair(pair_of(-1, -1, 0, 0, 1, 1, 2, 2));
    send_pair(pair_of(1, 0, 2, 1, 3, 0, 3, 1));
    send_pair(pair_of(0, 0, 3, 1, 1, 5, 2, -7));
    drain();

    // Random phases, one limit setting each, with a steady stretch in two of them.
    foreach (limits[p]) begin
      write_limit(limits[p]);
      steady = (p == 2 || p == 4);
      repeat (320) begin
        send_pair(random_pair());
        if (steady && $urandom_range(0, 99) == 0) steady = 0;
      end
      steady = 0;
      drain();
    end

    if (mismatches == 0 && pairs.awaited.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/spcp_pkg.sv
hdl/spcp_wmul.sv
hdl/spcp_div.sv
hdl/spcp_sqrt.sv
hdl/segment_pair_closest_points_core.sv
tb/sv/tb_segment_pair_closest_points_core.sv
